### design/obla_pkg.sv
`timescale 1ns / 1ps
package obla_pkg;

  localparam int LEVELS_DEF    = 64;
  localparam int MAX_DEPTH_DEF = 32;
  localparam int DEPTH_W       = 6;
  localparam logic [DEPTH_W-1:0] DEPTH_RST = 6'd32;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_RPT   = 1'b1;
  localparam logic SIDE_SELL = 1'b0;
  localparam logic SIDE_BUY  = 1'b1;

  localparam logic [31:0] VOL_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        req_type;
    logic        side;
    logic [31:0] price;
    logic [15:0] volume;
  } obla_in_t;

  typedef struct packed {
    logic        side_res;
    logic [31:0] price_res;
    logic [31:0] volume_res;
    logic        present;
    logic        overflow;
    logic        last;
  } obla_out_t;

endpackage

### design/order_book_level_aggregator.sv
`timescale 1ns / 1ps
// channel | ports                        | handshake
// input   | start, busy, in_data         | taken when start && !busy
// result  | out_valid, out_data          | one-cycle strobe, cannot be held off
// config  | cfg_valid, cfg_ready, cfg_data | written when valid && ready
//
// A two-word queue takes input while the back end works.
// Add order: one level table read per cycle until the price matches or the side's levels run out.
// Report: (2*ks + kb) scans of the side's open levels.
// Synchronous reset empties both books and clears overflow; depth resets to 32.
// The receiver cannot stall; busy rises only when the queue is full.
module order_book_level_aggregator import obla_pkg::*; #(
  parameter int LEVELS    = LEVELS_DEF,
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  obla_in_t           in_data,
  output logic               out_valid,
  output obla_out_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [DEPTH_W-1:0] cfg_data
);

  logic [DEPTH_W-1:0] depth_r;
  logic               q_valid, q_pop;
  obla_in_t           q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= DEPTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      depth_r <= cfg_data;
    end
  end

  obla_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  obla_back #(.LEVELS(LEVELS), .MAX_DEPTH(MAX_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .depth(depth_r),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
    .out_valid(out_valid), .out_data(out_data)
  );

endmodule

### design/obla_ram.sv
`timescale 1ns / 1ps
module obla_ram #(
  parameter int W = 64,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/obla_front.sv
`timescale 1ns / 1ps
module obla_front import obla_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  obla_in_t in_data,
  output logic     q_valid,
  output obla_in_t q_data,
  input  logic     q_pop
);

  // two-entry queue of accepted words
  obla_in_t   slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ (q_pop && q_valid);
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r] <= in_data;
    end
  end

endmodule

### design/obla_back.sv
`timescale 1ns / 1ps
module obla_back import obla_pkg::*; #(
  parameter int LEVELS    = LEVELS_DEF,
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [DEPTH_W-1:0] depth,
  input  logic               q_valid,
  input  obla_in_t           q_data,
  output logic               q_pop,
  output logic               out_valid,
  output obla_out_t          out_data
);

  localparam int AW = $clog2(LEVELS);
  localparam int CW = $clog2(LEVELS + 1);
  localparam int KW = $clog2(MAX_DEPTH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_AWR  = 3'd2;
  localparam logic [2:0] ST_NEXT = 3'd3;

  localparam logic [1:0] PH_SA = 2'd0; // find k-th lowest sell
  localparam logic [1:0] PH_SB = 2'd1; // sell out, highest first
  localparam logic [1:0] PH_B  = 2'd2; // buy out, highest first

  logic [2:0]    st_r, st_nxt;
  logic [1:0]    ph_r, ph_nxt;
  obla_in_t      cur_r, cur_nxt;
  logic          side_r, side_nxt;
  logic [CW-1:0] scnt_r, scnt_nxt, bcnt_r, bcnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] rd_r, rd_nxt;
  logic          rv_r, rv_nxt;
  logic [AW-1:0] ret_r, ret_nxt;
  logic          fnd_r, fnd_nxt;
  logic [31:0]   bp_r, bp_nxt, bv_r, bv_nxt;
  logic [AW-1:0] bi_r, bi_nxt;
  logic [31:0]   lo_r, lo_nxt;
  logic [32:0]   hi_r, hi_nxt;
  logic [KW-1:0] k_r, k_nxt, ks_r, ks_nxt, kb_r, kb_nxt;
  logic          ov_r, ov_nxt;
  obla_out_t     od_r, od_nxt;

  logic          s_we, b_we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   wdata, s_rd, b_rd, rd_sel;
  logic [CW-1:0] cnt_sel;
  logic [31:0]   rp, rvol;
  logic [32:0]   sum;
  logic [KW-1:0] d_eff;
  logic          cand;

  obla_ram #(.W(64), .D(LEVELS)) u_sell (
    .clk(clk), .we(s_we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(s_rd)
  );
  obla_ram #(.W(64), .D(LEVELS)) u_buy (
    .clk(clk), .we(b_we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(b_rd)
  );

  assign cnt_sel = side_r ? bcnt_r : scnt_r;
  assign rd_sel  = side_r ? b_rd : s_rd;
  assign rp      = rd_sel[63:32];
  assign rvol    = rd_sel[31:0];
  assign raddr   = rd_r[AW-1:0];
  assign sum     = {1'b0, bv_r} + {17'd0, cur_r.volume};

  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    if (depth == '0) begin
      d_eff = KW'(1);
    end else if (int'(depth) > MAX_DEPTH) begin
      d_eff = KW'(MAX_DEPTH);
    end else begin
      d_eff = KW'(depth);
    end
  end

  always_comb begin
    if (ph_r == PH_SA) begin
      cand = ((k_r == '0) || (rp > lo_r)) && (!fnd_r || (rp < bp_r));
    end else begin
      cand = ({1'b0, rp} < hi_r) && (!fnd_r || (rp > bp_r));
    end
  end

  always_comb begin
    st_nxt   = st_r;
    ph_nxt   = ph_r;
    cur_nxt  = cur_r;
    side_nxt = side_r;
    scnt_nxt = scnt_r;
    bcnt_nxt = bcnt_r;
    ovf_nxt  = ovf_r;
    rd_nxt   = rd_r;
    rv_nxt   = 1'b0;
    ret_nxt  = ret_r;
    fnd_nxt  = fnd_r;
    bp_nxt   = bp_r;
    bv_nxt   = bv_r;
    bi_nxt   = bi_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    k_nxt    = k_r;
    ks_nxt   = ks_r;
    kb_nxt   = kb_r;
    ov_nxt   = 1'b0;
    od_nxt   = od_r;
    q_pop    = 1'b0;
    s_we     = 1'b0;
    b_we     = 1'b0;
    waddr    = bi_r;
    wdata    = {cur_r.price, bv_r};

    unique case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          cur_nxt  = q_data;
          rd_nxt   = '0;
          fnd_nxt  = 1'b0;
          k_nxt    = '0;
          if (q_data.req_type == REQ_ADD) begin
            side_nxt = q_data.side;
            if ((q_data.side ? bcnt_r : scnt_r) == '0) begin
              st_nxt = ST_AWR;
            end else begin
              st_nxt = ST_SCAN;
            end
          end else begin
            ks_nxt = (int'(scnt_r) < int'(d_eff)) ? KW'(scnt_r) : d_eff;
            kb_nxt = (int'(bcnt_r) < int'(d_eff)) ? KW'(bcnt_r) : d_eff;
            if (scnt_r == '0 && bcnt_r == '0) begin
              ov_nxt = 1'b1;
              od_nxt = '{side_res: SIDE_SELL, price_res: '0, volume_res: '0,
                         present: 1'b0, overflow: ovf_r, last: 1'b1};
            end else if (scnt_r != '0) begin
              ph_nxt   = PH_SA;
              side_nxt = SIDE_SELL;
              st_nxt   = ST_SCAN;
            end else begin
              ph_nxt   = PH_B;
              side_nxt = SIDE_BUY;
              hi_nxt   = 33'h1_0000_0000;
              st_nxt   = ST_SCAN;
            end
          end
        end
      end

      ST_SCAN: begin
        // reads stream one a cycle, data lands in the next cycle
        if (rd_r < cnt_sel) begin
          rd_nxt  = rd_r + CW'(1);
          rv_nxt  = 1'b1;
          ret_nxt = rd_r[AW-1:0];
        end
        if (rv_r) begin
          if (cur_r.req_type == REQ_ADD) begin
            if (rp == cur_r.price) begin
              fnd_nxt = 1'b1;
              bi_nxt  = ret_r;
              bv_nxt  = rvol;
              rv_nxt  = 1'b0;
              st_nxt  = ST_AWR;
            end else if (CW'(ret_r) + CW'(1) == cnt_sel) begin
              st_nxt = ST_AWR;
            end
          end else begin
            if (cand) begin
              fnd_nxt = 1'b1;
              bp_nxt  = rp;
              bv_nxt  = rvol;
            end
            if (CW'(ret_r) + CW'(1) == cnt_sel) begin
              st_nxt = ST_NEXT;
            end
          end
        end
      end

      ST_AWR: begin
        st_nxt = ST_IDLE;
        if (fnd_r) begin
          wdata = {cur_r.price, sum[32] ? VOL_MAX : sum[31:0]};
          s_we  = (side_r == SIDE_SELL);
          b_we  = (side_r == SIDE_BUY);
        end else if (cnt_sel == CW'(LEVELS)) begin
          ovf_nxt = 1'b1;
        end else begin
          waddr = cnt_sel[AW-1:0];
          wdata = {cur_r.price, 16'd0, cur_r.volume};
          if (side_r == SIDE_SELL) begin
            s_we     = 1'b1;
            scnt_nxt = scnt_r + CW'(1);
          end else begin
            b_we     = 1'b1;
            bcnt_nxt = bcnt_r + CW'(1);
          end
        end
      end

      ST_NEXT: begin
        rd_nxt  = '0;
        fnd_nxt = 1'b0;
        k_nxt   = k_r + KW'(1);
        st_nxt  = ST_SCAN;
        unique case (ph_r)
          PH_SA: begin
            lo_nxt = bp_r;
            if (k_r + KW'(1) == ks_r) begin
              ph_nxt = PH_SB;
              hi_nxt = {1'b0, bp_r} + 33'd1;
              k_nxt  = '0;
            end
          end
          PH_SB, PH_B: begin
            ov_nxt = 1'b1;
            od_nxt = '{side_res: side_r, price_res: bp_r, volume_res: bv_r,
                       present: 1'b1, overflow: ovf_r, last: 1'b0};
            hi_nxt = {1'b0, bp_r};
            if (ph_r == PH_SB && k_r + KW'(1) == ks_r) begin
              if (kb_r != '0) begin
                ph_nxt   = PH_B;
                side_nxt = SIDE_BUY;
                hi_nxt   = 33'h1_0000_0000;
                k_nxt    = '0;
              end else begin
                od_nxt.last = 1'b1;
                st_nxt      = ST_IDLE;
              end
            end else if (ph_r == PH_B && k_r + KW'(1) == kb_r) begin
              od_nxt.last = 1'b1;
              st_nxt      = ST_IDLE;
            end
          end
          default: st_nxt = ST_IDLE;
        endcase
      end

      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      scnt_r <= '0;
      bcnt_r <= '0;
      ovf_r  <= 1'b0;
      rv_r   <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      scnt_r <= scnt_nxt;
      bcnt_r <= bcnt_nxt;
      ovf_r  <= ovf_nxt;
      rv_r   <= rv_nxt;
      ov_r   <= ov_nxt;
    end
    ph_r   <= ph_nxt;
    cur_r  <= cur_nxt;
    side_r <= side_nxt;
    rd_r   <= rd_nxt;
    ret_r  <= ret_nxt;
    fnd_r  <= fnd_nxt;
    bp_r   <= bp_nxt;
    bv_r   <= bv_nxt;
    bi_r   <= bi_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    k_r    <= k_nxt;
    ks_r   <= ks_nxt;
    kb_r   <= kb_nxt;
    od_r   <= od_nxt;
  end

endmodule

### tb/sv/tb_order_book_level_aggregator.sv
`timescale 1ns / 1ps
module tb_order_book_level_aggregator;
  import obla_pkg::*;

  localparam int NLEV       = LEVELS_DEF;
  localparam int CYCLE_CAP  = 20000000;
  localparam int SETTLE     = 400;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  obla_in_t           in_data = '0;
  logic               out_valid;
  obla_out_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [DEPTH_W-1:0] cfg_data = '0;

  order_book_level_aggregator DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow book
  logic [31:0]        sell_px [NLEV];
  logic [31:0]        sell_vol[NLEV];
  logic [31:0]        buy_px  [NLEV];
  logic [31:0]        buy_vol [NLEV];
  int                 n_sell = 0;
  int                 n_buy = 0;
  logic               ovf_seen = 1'b0;
  logic [DEPTH_W-1:0] depth_reg = DEPTH_RST;

  obla_out_t pending_levels[$];
  int        n_bad = 0;
  int        n_cycles = 0;
  bit        no_gaps = 1'b0;

  function automatic void book_add(input logic sd, input logic [31:0] px,
                                   input logic [15:0] vol);
    logic [32:0] sum;
    int cnt;
    cnt = (sd == SIDE_BUY) ? n_buy : n_sell;
    for (int i = 0; i < cnt; i++) begin
      if (((sd == SIDE_BUY) ? buy_px[i] : sell_px[i]) == px) begin
        sum = {1'b0, ((sd == SIDE_BUY) ? buy_vol[i] : sell_vol[i])} + {17'd0, vol};
        if (sum[32]) sum[31:0] = VOL_MAX;
        if (sd == SIDE_BUY) buy_vol[i] = sum[31:0];
        else sell_vol[i] = sum[31:0];
        return;
      end
    end
    if (cnt >= NLEV) begin
      ovf_seen = 1'b1;
      return;
    end
    if (sd == SIDE_BUY) begin
      buy_px[cnt] = px; buy_vol[cnt] = {16'd0, vol}; n_buy++;
    end else begin
      sell_px[cnt] = px; sell_vol[cnt] = {16'd0, vol}; n_sell++;
    end
  endfunction

  // expected report words, highest price first on both sides
  function automatic void book_report();
    logic [31:0] tp[NLEV];
    logic [31:0] tv[NLEV];
    logic [31:0] p, v;
    obla_out_t   w;
    int d, k, j, first;
    d = depth_reg;
    if (d == 0) d = 1;
    if (d > MAX_DEPTH_DEF) d = MAX_DEPTH_DEF;
    if (n_sell == 0 && n_buy == 0) begin
      w = '0;
      w.overflow = ovf_seen;
      w.last = 1'b1;
      pending_levels = {pending_levels, w};
      return;
    end
    first = pending_levels.size();
    for (int s = 0; s < 2; s++) begin
      int cnt;
      cnt = s ? n_buy : n_sell;
      // sell sorted ascending, buy descending
      for (int i = 0; i < cnt; i++) begin
        p = s ? buy_px[i] : sell_px[i];
        v = s ? buy_vol[i] : sell_vol[i];
        j = i;
        while (j > 0 && (s ? (tp[j-1] < p) : (tp[j-1] > p))) begin
          tp[j] = tp[j-1]; tv[j] = tv[j-1]; j--;
        end
        tp[j] = p; tv[j] = v;
      end
      k = (cnt < d) ? cnt : d;
      for (int i = 0; i < k; i++) begin
        j = s ? i : k - 1 - i;
        w.side_res   = s ? SIDE_BUY : SIDE_SELL;
        w.price_res  = tp[j];
        w.volume_res = tv[j];
        w.present    = 1'b1;
        w.overflow   = ovf_seen;
        w.last       = 1'b0;
        pending_levels = {pending_levels, w};
      end
    end
    if (pending_levels.size() > first)
      pending_levels[pending_levels.size()-1].last = 1'b1;
  endfunction

  function automatic void book_step(input obla_in_t it);
    if (it.req_type == REQ_ADD) book_add(it.side, it.price, it.volume);
    else book_report();
  endfunction

  task automatic idle_gap();
    if (!no_gaps && $urandom_range(0, 99) < 19) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // start is left high; the next word or a gap decides what follows
  task automatic send_word(input obla_in_t it, input bit typed, input obla_out_t want);
    idle_gap();
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy !== 1'b0);
    if (typed) pending_levels = {pending_levels, want};
    else book_step(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_depth(input logic [DEPTH_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    depth_reg = val;
    cfg_valid <= 1'b0;
  endtask

  function automatic obla_in_t rand_word();
    obla_in_t it;
    int r;
    it.req_type = ($urandom_range(0, 99) < 10) ? REQ_RPT : REQ_ADD;
    it.side     = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 55) it.price = 32'h4000_0000 + $urandom_range(0, 40);
    else if (r < 85) it.price = $urandom;
    else it.price = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    r = $urandom_range(0, 99);
    if (r < 10) it.volume = 16'h0;
    else if (r < 20) it.volume = 16'hFFFF;
    else it.volume = 16'($urandom_range(0, 16'hFFFF));
    return it;
  endfunction

  // checker
  always @(posedge clk) begin
    obla_out_t w;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_levels.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result word %h", out_data);
      end else begin
        w = pending_levels.pop_front();
        if (out_data.side_res !== w.side_res || out_data.price_res !== w.price_res ||
            out_data.volume_res !== w.volume_res || out_data.present !== w.present ||
            out_data.overflow !== w.overflow || out_data.last !== w.last) begin
          n_bad++;
          if (n_bad <= 10)
            $display({"mismatch: exp side %b px %h vol %h pres %b ovf %b last %b",
                      " / got %b %h %h %b %b %b"},
                     w.side_res, w.price_res, w.volume_res, w.present, w.overflow, w.last,
                     out_data.side_res, out_data.price_res, out_data.volume_res,
                     out_data.present, out_data.overflow, out_data.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  typedef struct {
    obla_in_t  it;
    bit        typed;
    obla_out_t want;
  } stim_row_t;

  stim_row_t rows[] = '{
    '{'{REQ_RPT, SIDE_SELL, 32'h0, 16'h0}, 1'b1, '{1'b0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1}},
    '{'{REQ_ADD, SIDE_SELL, 32'hFFFF_FFFF, 16'hFFFF}, 1'b0, '0},
    '{'{REQ_RPT, SIDE_BUY, 32'h0, 16'h0},
      1'b1, '{SIDE_SELL, 32'hFFFF_FFFF, 32'h0000_FFFF, 1'b1, 1'b0, 1'b1}},
    '{'{REQ_ADD, SIDE_SELL, 32'h0, 16'h0}, 1'b0, '0},
    '{'{REQ_ADD, SIDE_BUY, 32'h0, 16'hFFFF}, 1'b0, '0},
    '{'{REQ_ADD, SIDE_BUY, 32'hFFFF_FFFF, 16'h0}, 1'b0, '0},
    '{'{REQ_ADD, SIDE_BUY, 32'hFFFF_FFFF, 16'hFFFF}, 1'b0, '0},
    '{'{REQ_ADD, SIDE_SELL, 32'h1234_5678, 16'h0001}, 1'b0, '0},
    '{'{REQ_RPT, SIDE_SELL, 32'hFFFF_FFFF, 16'hFFFF}, 1'b0, '0},
    '{'{REQ_ADD, SIDE_BUY, 32'h8000_0000, 16'h8000}, 1'b0, '0},
    '{'{REQ_ADD, SIDE_SELL, 32'h7FFF_FFFF, 16'h7FFF}, 1'b0, '0},
    '{'{REQ_ADD, SIDE_SELL, 32'h5555_5555, 16'h5555}, 1'b0, '0},
    '{'{REQ_ADD, SIDE_BUY, 32'hAAAA_AAAA, 16'hAAAA}, 1'b0, '0},
    '{'{REQ_RPT, SIDE_BUY, 32'h0, 16'h0}, 1'b0, '0}
  };

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_word(rows[i].it, rows[i].typed, rows[i].want);

    // zero depth reads as one, above the cap as the cap
    set_depth(6'd0);
    send_word('{REQ_RPT, SIDE_SELL, 32'h0, 16'h0}, 1'b0, '0);
    set_depth(6'd63);
    send_word('{REQ_RPT, SIDE_SELL, 32'h0, 16'h0}, 1'b0, '0);

    // pile volume onto one buy level, back to back
    no_gaps = 1'b1;
    for (int i = 0; i < 10; i++)
      send_word('{REQ_ADD, SIDE_BUY, 32'h5A5A_0001, 16'hFFFF}, 1'b0, '0);
    send_word('{REQ_RPT, SIDE_SELL, 32'h0, 16'h0}, 1'b0, '0);
    no_gaps = 1'b0;

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_depth(6'd1);
        1: set_depth(6'd32);
        2: set_depth(6'($urandom_range(2, 31)));
        3: set_depth(6'd0);
        default: set_depth(6'd63);
      endcase
      for (int i = 0; i < 80; i++) begin
        no_gaps = (ph == 1 && i >= 20 && i < 70);
        send_word(rand_word(), 1'b0, '0);
      end
      no_gaps = 1'b0;
    end
    send_word('{REQ_RPT, SIDE_SELL, 32'h0, 16'h0}, 1'b0, '0);

    drain();
    if (n_bad == 0 && pending_levels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
design/obla_pkg.sv
design/obla_ram.sv
design/obla_front.sv
design/obla_back.sv
design/order_book_level_aggregator.sv
tb/sv/tb_order_book_level_aggregator.sv
